@@ hw/rtl/bff_pkg.sv @@
// bff_pkg: types, codes and constants shared by the bitmap flood fill core.
// Holds the channel payload structs, the command codes, the cell control
// struct and the controller state enum. Depends on nothing.
package bff_pkg;

	// Default canvas size
	localparam int DEF_ROW_COUNT = 16;
	localparam int DEF_COL_COUNT = 32;

	// Widths fixed by the channel fields
	localparam int CMD_W   = 2;
	localparam int ROW_W   = 4;
	localparam int COL_W   = 5;
	localparam int COUNT_W = 10;
	// Wide enough to compare any coordinate against a size of up to 256
	localparam int COORD_W = 9;
	// Sequencer step counter, covers indexes up to 255
	localparam int STEP_W  = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FILL  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             pixel_in;
	} in_item_t;

	typedef struct packed {
		logic               pixel_out;
		logic [COUNT_W-1:0] filled_count;
	} out_item_t;

	// Operation broadcast to every row cell
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_SEED,
		CELL_GROW,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              pixel;
		logic [STEP_W-1:0] step;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_SEED,
		ST_GROW,
		ST_COUNT,
		ST_SUM,
		ST_RESP
	} fsm_state_t;

endpackage

@@ hw/rtl/bff_cell.sv @@
// bff_cell: one canvas row. Holds the row's pixels, the fill frontier and
// region marks, and the per-row links of the done, read and count chains.
// Depends on bff_pkg.
module bff_cell import bff_pkg::*; #(
	parameter int COL_COUNT  = DEF_COL_COUNT,
	parameter int CELL_INDEX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctl_t            ctl,
	input  logic [COL_COUNT-1:0] front_above,
	input  logic [COL_COUNT-1:0] front_below,
	output logic [COL_COUNT-1:0] front,
	input  logic                 act_in,
	output logic                 act_out,
	input  logic                 rd_in,
	output logic                 rd_out,
	input  logic [COUNT_W-1:0]   sum_in,
	output logic [COUNT_W-1:0]   sum_out
);

	localparam int COL_IW = $clog2(COL_COUNT);
	localparam int CNT_W  = $clog2(COL_COUNT + 1);

	logic [COL_COUNT-1:0] white_q, white_d;   // 1 = white pixel
	logic [COL_COUNT-1:0] front_q, front_d;   // pixels blackened last cycle
	logic [COL_COUNT-1:0] mark_q, mark_d;     // pixels blackened by this fill
	logic                 act_q, act_d;       // growth seen since last sample
	logic                 chain_q, chain_d;   // done chain link
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic                 rd_q;
	logic [COUNT_W-1:0]   sum_q;

	logic                 sel;
	logic                 sample;
	logic [COORD_W-1:0]   col_ext;
	logic [COL_IW-1:0]    col_idx;
	logic [COL_COUNT-1:0] col_hot;
	logic [COL_COUNT-1:0] grow;
	logic                 grow_any;
	logic [COUNT_W:0]     sum_wide;

	// Row select, column decode
	assign sel     = (COORD_W'(ctl.row) == COORD_W'(CELL_INDEX));
	assign sample  = (ctl.step == STEP_W'(CELL_INDEX));
	assign col_ext = COORD_W'(ctl.col);
	assign col_idx = col_ext[COL_IW-1:0];
	assign col_hot = {{(COL_COUNT-1){1'b0}}, 1'b1} << col_idx;

	// One step of 4-connected growth into white pixels
	assign grow     = white_q & ((front_q << 1) | (front_q >> 1) | front_above | front_below);
	assign grow_any = |grow;

	// Cell state update
	always_comb begin
		white_d = white_q;
		front_d = front_q;
		mark_d  = mark_q;
		act_d   = act_q;
		chain_d = chain_q;
		cnt_d   = cnt_q;
		case (ctl.op)
			CELL_WRITE: begin
				if (sel) begin
					white_d[col_idx] = ctl.pixel;
				end
			end
			CELL_SEED: begin
				front_d = '0;
				mark_d  = '0;
				act_d   = 1'b0;
				cnt_d   = '0;
				if (sel) begin
					white_d = white_q & ~col_hot;
					front_d = white_q & col_hot;
					mark_d  = white_q & col_hot;
				end
			end
			CELL_GROW: begin
				white_d = white_q & ~grow;
				front_d = grow;
				mark_d  = mark_q | grow;
				// sampled window runs from the previous sample up to this cycle
				if (sample) begin
					act_d   = 1'b0;
					chain_d = act_in | act_q | grow_any;
				end else begin
					act_d = act_q | grow_any;
				end
			end
			CELL_SHIFT: begin
				mark_d = mark_q >> 1;
				cnt_d  = cnt_q + CNT_W'(mark_q[0]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_q <= '1;
			front_q <= '0;
			mark_q  <= '0;
			act_q   <= 1'b0;
			chain_q <= 1'b0;
		end else begin
			white_q <= white_d;
			front_q <= front_d;
			mark_q  <= mark_d;
			act_q   <= act_d;
			chain_q <= chain_d;
		end
	end

	// Read and count chains, saturating sum
	assign sum_wide = {1'b0, sum_in} + (COUNT_W + 1)'(cnt_q);

	always_ff @(posedge clk) begin
		cnt_q <= cnt_d;
		rd_q  <= sel ? white_q[col_idx] : rd_in;
		sum_q <= sum_wide[COUNT_W] ? COUNT_MAX : sum_wide[COUNT_W-1:0];
	end

	assign front   = front_q;
	assign act_out = chain_q;
	assign rd_out  = rd_q;
	assign sum_out = sum_q;

endmodule

@@ hw/rtl/bff_ctrl.sv @@
// bff_ctrl: command sequencer and result register of the flood fill core.
// Drives the broadcast cell control and reads the ends of the cell chains.
// Depends on bff_pkg.
module bff_ctrl import bff_pkg::*; #(
	parameter int ROW_COUNT = DEF_ROW_COUNT,
	parameter int COL_COUNT = DEF_COL_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_data,
	output cell_ctl_t          ctl,
	input  logic               act_last,
	input  logic               rd_last,
	input  logic [COUNT_W-1:0] sum_last
);

	fsm_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              first_pass_q;
	logic              out_valid_q;
	out_item_t         out_q;
	in_item_t          req_q;
	logic              on_q;

	logic              in_fire;
	logic              in_on;
	logic              row_end;
	logic              col_end;
	logic              out_load;
	out_item_t         result;

	assign in_fire = in_valid && (state_q == ST_IDLE);
	assign in_on   = (COORD_W'(in_data.row) < COORD_W'(ROW_COUNT)) &&
	                 (COORD_W'(in_data.col) < COORD_W'(COL_COUNT));
	assign row_end = (step_q == STEP_W'(ROW_COUNT - 1));
	assign col_end = (step_q == STEP_W'(COL_COUNT - 1));
	assign out_load = (state_q == ST_RESP) && (!out_valid_q || out_ready);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_on && in_data.command == CMD_WRITE) begin
						state_d = ST_WRITE;
					end else if (in_on && in_data.command == CMD_READ) begin
						state_d = ST_READ;
					end else if (in_on && in_data.command == CMD_FILL) begin
						state_d = ST_SEED;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_WRITE: state_d = ST_RESP;
			ST_READ: begin
				if (row_end) begin
					state_d = ST_RESP;
				end
			end
			ST_SEED: state_d = ST_GROW;
			ST_GROW: begin
				// a full pass with no growth anywhere ends the fill
				if (step_q == '0 && !first_pass_q && !act_last) begin
					state_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				if (col_end) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (row_end) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Step counter: restarts on each state change, wraps per pass while growing
	always_comb begin
		if (state_d != state_q) begin
			step_d = '0;
		end else if (state_q == ST_GROW && row_end) begin
			step_d = '0;
		end else begin
			step_d = step_q + 1'b1;
		end
	end

	// Cell control and result
	always_comb begin
		ctl.row   = req_q.row;
		ctl.col   = req_q.col;
		ctl.pixel = req_q.pixel_in;
		ctl.step  = step_q;
		case (state_q)
			ST_WRITE: ctl.op = CELL_WRITE;
			ST_SEED:  ctl.op = CELL_SEED;
			ST_GROW:  ctl.op = CELL_GROW;
			ST_COUNT: ctl.op = CELL_SHIFT;
			default:  ctl.op = CELL_HOLD;
		endcase
		result.pixel_out    = (on_q && req_q.command == CMD_READ) ? rd_last : 1'b0;
		result.filled_count = (on_q && req_q.command == CMD_FILL) ? sum_last : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			first_pass_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (state_q == ST_SEED) begin
				first_pass_q <= 1'b1;
			end else if (state_q == ST_GROW && row_end) begin
				first_pass_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request capture and output register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q <= in_data;
			on_q  <= in_on;
		end
		if (out_load) begin
			out_q <= result;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ hw/rtl/bitmap_flood_fill_core.sv @@
// bitmap_flood_fill_core: top level of the one-bit canvas with pixel write,
// pixel read and 4-connected flood fill. Depends on bff_pkg, bff_ctrl and
// bff_cell.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------
//   in      | in        | in_valid / in_ready  | in_data  (command, row, col, pixel_in)
//   out     | out       | out_valid/out_ready  | out_data (pixel_out, filled_count)
//
// One command at a time. A read passes the pixel down the read chain through
// the row cells. A fill grows the region until a full pass of the done chain
// sees no growth, then counts each row's marks and sums them down the count
// chain: the frontier moves one pixel per cycle and the done chain samples
// one row per cycle.
// Reset leaves the whole canvas white; no clearing pass is needed.
// A result waiting on out holds only its own register; the next command is
// taken meanwhile and waits at the end of its work for the register.
module bitmap_flood_fill_core import bff_pkg::*; #(
	parameter int ROW_COUNT = DEF_ROW_COUNT,
	parameter int COL_COUNT = DEF_COL_COUNT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	cell_ctl_t            ctl;
	logic [COL_COUNT-1:0] front [ROW_COUNT];
	logic                 act_chain [ROW_COUNT];
	logic                 rd_chain [ROW_COUNT];
	logic [COUNT_W-1:0]   sum_chain [ROW_COUNT];

	// Sequencer
	bff_ctrl #(
		.ROW_COUNT (ROW_COUNT),
		.COL_COUNT (COL_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.ctl       (ctl),
		.act_last  (act_chain[ROW_COUNT-1]),
		.rd_last   (rd_chain[ROW_COUNT-1]),
		.sum_last  (sum_chain[ROW_COUNT-1])
	);

	// Row cells, linked to their upper and lower neighbors
	for (genvar gi = 0; gi < ROW_COUNT; gi++) begin : g_cell
		logic [COL_COUNT-1:0] above;
		logic [COL_COUNT-1:0] below;
		logic                 act_in;
		logic                 rd_in;
		logic [COUNT_W-1:0]   sum_in;

		if (gi == 0) begin : g_top
			assign above  = '0;
			assign act_in = 1'b0;
			assign rd_in  = 1'b0;
			assign sum_in = '0;
		end else begin : g_inner
			assign above  = front[gi-1];
			assign act_in = act_chain[gi-1];
			assign rd_in  = rd_chain[gi-1];
			assign sum_in = sum_chain[gi-1];
		end

		if (gi == ROW_COUNT - 1) begin : g_bottom
			assign below = '0;
		end else begin : g_upper
			assign below = front[gi+1];
		end

		bff_cell #(
			.COL_COUNT  (COL_COUNT),
			.CELL_INDEX (gi)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.front_above (above),
			.front_below (below),
			.front       (front[gi]),
			.act_in      (act_in),
			.act_out     (act_chain[gi]),
			.rd_in       (rd_in),
			.rd_out      (rd_chain[gi]),
			.sum_in      (sum_in),
			.sum_out     (sum_chain[gi])
		);
	end

endmodule

@@ hw/rtl/bff_checker.sv @@
// bff_checker: port-level assertions for bitmap_flood_fill_core, attached
// by the bind statement at the end of this file. Depends on bff_pkg.
module bff_checker import bff_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// One command at a time: busy right after a transfer in
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second command taken while busy");

	// No result appears in the cycle right after a command is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared right after command transfer");

	// A result is a read or a fill count, never both
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.pixel_out && out_data.filled_count != '0))
		else $error("result carries both a pixel and a count");

endmodule

bind bitmap_flood_fill_core bff_checker u_bff_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
